[rtl/core/bfgim_pkg.sv]
package bfgim_pkg;

	localparam int MAX_CELLS_PER_SIDE = 1023;
	localparam int CELLS_RESET        = 16;
	localparam int QUO_W              = 11;   // quotient bits of (k - 4n) / (n - 1)

	typedef struct packed {
		logic [9:0]  n;
		logic [9:0]  d;       // n - 1
		logic [10:0] n2;
		logic [11:0] n3;
		logic [11:0] n4;
		logic [20:0] nodes;   // (n + 1)^2
	} geom_t;

	typedef struct packed {
		logic              kind;
		logic              illegal;
		logic              interior;
		logic [9:0]        col;
		logic [9:0]        row;
		logic [19:0]       rem;
		logic [QUO_W-1:0]  quo;
	} item_t;

	typedef struct packed {
		logic        kind;
		logic        illegal;
		logic [9:0]  col;
		logic [9:0]  row;
		logic [3:0]  vmask;   // left, right, below, above
	} coord_t;

	function automatic geom_t geom_of(input logic [9:0] v);
		geom_t       g;
		logic [10:0] n1;
		logic [9:0]  n;
		n = v;
		if (v < 10'd2)
			n = 10'd2;
		if (32'(v) > MAX_CELLS_PER_SIDE)
			n = 10'(MAX_CELLS_PER_SIDE);
		n1 = 11'(n) + 11'd1;
		g.n     = n;
		g.d     = n - 10'd1;
		g.n2    = 11'(n) << 1;
		g.n3    = 12'(n) + (12'(n) << 1);
		g.n4    = 12'(n) << 2;
		g.nodes = 21'(n1) * 21'(n1);
		return g;
	endfunction

	// Running index of node (c, r); p = (n - 1) * (r - 1) for interior rows.
	function automatic logic [19:0] cti(input geom_t g, input logic [10:0] c,
		input logic [10:0] r, input logic [19:0] p);
		logic [21:0] t;
		if (r == 11'd0)
			t = 22'(c);
		else if (c == 11'(g.n))
			t = 22'(g.n) + 22'(r);
		else if (r == 11'(g.n))
			t = 22'(g.n3) - 22'(c);
		else if (c == 11'd0)
			t = 22'(g.n4) - 22'(r);
		else
			t = 22'(g.n4) + 22'(p) + 22'(c) - 22'd1;
		return t[19:0];
	endfunction

endpackage

[rtl/core/bfgim_front.sv]
module bfgim_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  bfgim_pkg::geom_t     geom,
	input  logic                 in_vld,
	input  logic                 kind,
	input  logic [19:0]          k,
	input  logic [9:0]           cin,
	input  logic [9:0]           rin,
	output logic                 vld_s1,
	output bfgim_pkg::item_t     item_s1
);

	bfgim_pkg::item_t nxt;
	logic [11:0] t12;

	always_comb begin
		nxt = '0;
		t12 = '0;
		nxt.kind = kind;
		if (kind) begin
			nxt.col = cin;
			nxt.row = rin;
			nxt.illegal = (cin > geom.n) || (rin > geom.n);
		end else if (k < 20'(geom.n)) begin
			nxt.col = k[9:0];
		end else if (k < 20'(geom.n2)) begin
			nxt.col = geom.n;
			nxt.row = 10'(k - 20'(geom.n));
		end else if (k < 20'(geom.n3)) begin
			t12 = geom.n3 - k[11:0];
			nxt.col = t12[9:0];
			nxt.row = geom.n;
		end else if (k < 20'(geom.n4)) begin
			t12 = geom.n4 - k[11:0];
			nxt.row = t12[9:0];
		end else if (21'(k) < geom.nodes) begin
			nxt.interior = 1'b1;
			nxt.rem = k - 20'(geom.n4);
		end else begin
			nxt.illegal = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1 <= nxt;
		end
	end

endmodule

[rtl/core/bfgim_divider.sv]
module bfgim_divider (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  logic [9:0]           d,
	input  logic                 in_vld,
	input  bfgim_pkg::item_t     in_item,
	output logic                 out_vld,
	output bfgim_pkg::item_t     out_item
);

	// One quotient bit per stage, most significant first.
	logic             vld_s [bfgim_pkg::QUO_W+1];
	bfgim_pkg::item_t div_s [bfgim_pkg::QUO_W+1];

	assign vld_s[0] = in_vld;
	assign div_s[0] = in_item;

	for (genvar s = 0; s < bfgim_pkg::QUO_W; s++) begin : g_stage
		localparam int B = bfgim_pkg::QUO_W - 1 - s;
		bfgim_pkg::item_t nxt;
		logic [20:0]      sub;

		always_comb begin
			nxt = div_s[s];
			sub = 21'(d) << B;
			if (div_s[s].interior && (21'(div_s[s].rem) >= sub)) begin
				nxt.rem = 20'(21'(div_s[s].rem) - sub);
				nxt.quo[B] = 1'b1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[s+1] <= 1'b0;
			end else if (adv) begin
				vld_s[s+1] <= vld_s[s];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				div_s[s+1] <= nxt;
			end
		end
	end

	assign out_vld  = vld_s[bfgim_pkg::QUO_W];
	assign out_item = div_s[bfgim_pkg::QUO_W];

endmodule

[rtl/core/bfgim_back.sv]
module bfgim_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  bfgim_pkg::geom_t     geom,
	input  logic                 in_vld,
	input  bfgim_pkg::item_t     in_item,
	output logic                 vld_c,
	output logic [9:0]           column_out,
	output logic [9:0]           row_out,
	output logic [19:0]          index_out,
	output logic [19:0]          left_index,
	output logic [19:0]          right_index,
	output logic [19:0]          below_index,
	output logic [19:0]          above_index,
	output logic [3:0]           neighbour_valid,
	output logic                 illegal
);

	bfgim_pkg::coord_t ca, co_a, co_b;
	logic              vld_a, vld_b;
	logic [19:0]       p_b;
	logic              ok;

	// stage A: final coordinates and on-grid mask
	always_comb begin
		ca.kind    = in_item.kind;
		ca.illegal = in_item.illegal;
		ca.col     = in_item.interior ? in_item.rem[9:0] + 10'd1 : in_item.col;
		ca.row     = in_item.interior ? in_item.quo[9:0] + 10'd1 : in_item.row;
		ok         = !in_item.kind && !in_item.illegal;
		ca.vmask   = {ok && (ca.row < geom.n), ok && (ca.row != 10'd0),
		              ok && (ca.col < geom.n), ok && (ca.col != 10'd0)};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_a <= 1'b0;
			vld_b <= 1'b0;
			vld_c <= 1'b0;
		end else if (adv) begin
			vld_a <= in_vld;
			vld_b <= vld_a;
			vld_c <= vld_b;
		end
	end

	logic [10:0] c11, r11;
	logic        sel0, sel1;
	assign c11  = 11'(co_b.col);
	assign r11  = 11'(co_b.row);
	assign sel0 = !co_b.kind && !co_b.illegal;
	assign sel1 = co_b.kind && !co_b.illegal;

	always_ff @(posedge clk) begin
		if (adv) begin
			co_a <= ca;
			// stage B: row base product; on row 0 this is -d so the row 1 base is 0
			co_b <= co_a;
			p_b  <= 20'(geom.d) * (20'(co_a.row) - 20'd1);
			// stage C: indices
			column_out      <= sel0 ? co_b.col : '0;
			row_out         <= sel0 ? co_b.row : '0;
			index_out       <= sel1 ? bfgim_pkg::cti(geom, c11, r11, p_b) : '0;
			left_index      <= co_b.vmask[0] ?
				bfgim_pkg::cti(geom, c11 - 11'd1, r11, p_b) : '0;
			right_index     <= co_b.vmask[1] ?
				bfgim_pkg::cti(geom, c11 + 11'd1, r11, p_b) : '0;
			below_index     <= co_b.vmask[2] ?
				bfgim_pkg::cti(geom, c11, r11 - 11'd1, p_b - 20'(geom.d)) : '0;
			above_index     <= co_b.vmask[3] ?
				bfgim_pkg::cti(geom, c11, r11 + 11'd1, p_b + 20'(geom.d)) : '0;
			neighbour_valid <= co_b.vmask;
			illegal         <= co_b.illegal;
		end
	end

endmodule

[rtl/core/boundary_first_grid_index_mapper.sv]
// Boundary-first node index mapper for an N x N cell grid ((N+1)^2 nodes).
// Boundary nodes are numbered first, counter-clockwise from the bottom-left
// corner, then interior nodes row by row. kind 0 (s_tuser) maps a running
// index to column/row plus the four neighbour indices with valid bits; kind 1
// maps column/row to a running index. Off-grid input sets the illegal flag
// (m_tuser) and zeroes the other fields. Throughput is one transfer per
// cycle while the output is not stalled. The pipeline has one classify
// stage, eleven restoring-divider stages (one quotient bit each, dividing
// by N-1), and three stages for coordinates, the row-base multiply and the
// index assembly. A stall on the output freezes the whole pipeline.
// cells_per_side is written on the cfg channel (always ready); values below
// 2 act as 2. Write it only while the pipeline is empty.
module boundary_first_grid_index_mapper (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [9:0]   cfg_data,     // cells_per_side
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [39:0]  s_tdata,      // running_index[19:0], column_in[29:20], row_in[39:30]
	input  logic         s_tuser,      // kind
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata,      // column_out[9:0], row_out[19:10], index_out[39:20],
	                                   // left[59:40], right[79:60], below[99:80],
	                                   // above[119:100], neighbour_valid[123:120], zero pad
	output logic         m_tuser       // illegal
);

	bfgim_pkg::geom_t geom_q;
	logic             adv;
	logic             vld_s1, vld_d;
	bfgim_pkg::item_t item_s1, item_d;

	logic [9:0]  column_out, row_out;
	logic [19:0] index_out, left_index, right_index, below_index, above_index;
	logic [3:0]  neighbour_valid;

	assign cfg_ready = 1'b1;

	// derived geometry recomputed at write time so the next item sees it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			geom_q <= bfgim_pkg::geom_of(10'(bfgim_pkg::CELLS_RESET));
		end else if (cfg_valid) begin
			geom_q <= bfgim_pkg::geom_of(cfg_data);
		end
	end

	// global advance: output register empty or being drained
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	bfgim_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.geom    (geom_q),
		.in_vld  (s_tvalid),
		.kind    (s_tuser),
		.k       (s_tdata[19:0]),
		.cin     (s_tdata[29:20]),
		.rin     (s_tdata[39:30]),
		.vld_s1  (vld_s1),
		.item_s1 (item_s1)
	);

	bfgim_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.d        (geom_q.d),
		.in_vld   (vld_s1),
		.in_item  (item_s1),
		.out_vld  (vld_d),
		.out_item (item_d)
	);

	bfgim_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.adv             (adv),
		.geom            (geom_q),
		.in_vld          (vld_d),
		.in_item         (item_d),
		.vld_c           (m_tvalid),
		.column_out      (column_out),
		.row_out         (row_out),
		.index_out       (index_out),
		.left_index      (left_index),
		.right_index     (right_index),
		.below_index     (below_index),
		.above_index     (above_index),
		.neighbour_valid (neighbour_valid),
		.illegal         (m_tuser)
	);

	assign m_tdata = {4'd0, neighbour_valid, above_index, below_index, right_index,
	                  left_index, index_out, row_out, column_out};

	a_geom_min: assert property (@(posedge clk) disable iff (!arst_n)
		geom_q.n >= 10'd2) else $error("effective cells_per_side below 2");

	a_illegal_no_nbr: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> neighbour_valid == 4'd0)
		else $error("neighbour valid on illegal transfer");

	a_left_col: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && neighbour_valid[0] |-> column_out != 10'd0)
		else $error("left neighbour valid at column 0");

	a_below_row: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && neighbour_valid[2] |-> row_out != 10'd0)
		else $error("below neighbour valid at row 0");

endmodule

[tb/grid_index_checker.sv]
`timescale 1ns / 100ps

module grid_index_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_valid,
	input  logic         cfg_ready,
	input  logic [9:0]   cfg_data,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [39:0]  s_tdata,
	input  logic         s_tuser,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [127:0] m_tdata,
	input  logic         m_tuser,
	output int           errors,
	output int           pending
);

	typedef struct packed {
		logic [9:0]  col;
		logic [9:0]  row;
		logic [19:0] idx;
		logic [19:0] left;
		logic [19:0] right;
		logic [19:0] below;
		logic [19:0] above;
		logic [3:0]  nvalid;
		logic        illegal;
	} grid_answer_t;

	logic [9:0]   side_reg;
	grid_answer_t answers[$];

	function automatic int clamp_side(input logic [9:0] v);
		int n;
		n = v;
		if (n < 2)
			n = 2;
		if (n > bfgim_pkg::MAX_CELLS_PER_SIDE)
			n = bfgim_pkg::MAX_CELLS_PER_SIDE;
		return n;
	endfunction

	function automatic int node_number(input int n, input int c, input int r);
		if (r == 0)
			return c;
		if (c == n)
			return n + r;
		if (r == n)
			return 3 * n - c;
		if (c == 0)
			return 4 * n - r;
		return 4 * n + (n - 1) * (r - 1) + (c - 1);
	endfunction

	function automatic grid_answer_t map_query(input int n, input logic kind,
		input logic [39:0] d);
		grid_answer_t a;
		int k, c, r, ci, ri;
		a = '0;
		k = d[19:0];
		ci = d[29:20];
		ri = d[39:30];
		if (kind) begin
			if (ci > n || ri > n)
				a.illegal = 1'b1;
			else
				a.idx = 20'(node_number(n, ci, ri));
		end else if (k >= (n + 1) * (n + 1)) begin
			a.illegal = 1'b1;
		end else begin
			if (k < n) begin
				c = k; r = 0;
			end else if (k < 2 * n) begin
				c = n; r = k - n;
			end else if (k < 3 * n) begin
				c = 3 * n - k; r = n;
			end else if (k < 4 * n) begin
				c = 0; r = 4 * n - k;
			end else begin
				c = (k - 4 * n) % (n - 1) + 1;
				r = (k - 4 * n) / (n - 1) + 1;
			end
			a.col = 10'(c);
			a.row = 10'(r);
			if (c > 0) begin
				a.left = 20'(node_number(n, c - 1, r)); a.nvalid[0] = 1'b1;
			end
			if (c < n) begin
				a.right = 20'(node_number(n, c + 1, r)); a.nvalid[1] = 1'b1;
			end
			if (r > 0) begin
				a.below = 20'(node_number(n, c, r - 1)); a.nvalid[2] = 1'b1;
			end
			if (r < n) begin
				a.above = 20'(node_number(n, c, r + 1)); a.nvalid[3] = 1'b1;
			end
		end
		return a;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		grid_answer_t want, got;
		if (!arst_n) begin
			side_reg <= 10'(bfgim_pkg::CELLS_RESET);
			answers.delete();
			errors  <= 0;
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				side_reg <= cfg_data;
			if (s_tvalid && s_tready)
				answers.push_back(map_query(clamp_side(side_reg), s_tuser, s_tdata));
			if (m_tvalid && m_tready) begin
				got = {m_tdata[9:0], m_tdata[19:10], m_tdata[39:20], m_tdata[59:40],
					m_tdata[79:60], m_tdata[99:80], m_tdata[119:100],
					m_tdata[123:120], m_tuser};
				if (answers.size() == 0) begin
					if (errors < 10)
						$display("unexpected result transfer %h", m_tdata);
					errors <= errors + 1;
				end else begin
					want = answers.pop_front();
					if (got !== want || m_tdata[127:124] !== 4'd0) begin
						if (errors < 10)
							$display("mismatch: exp %h act %h (pad %h)", want, got,
								m_tdata[127:124]);
						errors <= errors + 1;
					end
				end
			end
			pending <= answers.size();
		end
	end
endmodule

[tb/tb.sv]
`timescale 1ns / 100ps

module tb;
	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [9:0]   cfg_data = '0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [39:0]  s_tdata = '0;
	logic         s_tuser = 1'b0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [127:0] m_tdata;
	logic         m_tuser;
	int           errors, pending;
	int           send_idle = 0, recv_stall = 0;  // percent
	int           cur_side = 16;
	longint       cycles = 0;

	always #5 clk = ~clk;

	boundary_first_grid_index_mapper uut (.*);

	grid_index_checker chk (.*);

	// Watchdog: reports failure and ends a run that does not finish.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("boundary_first_grid_index_mapper test failed");
			$finish;
		end
	end

	// Receiver: random back-pressure per current phase.
	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= recv_stall);

	// Quiesce, then hold off for pipeline depth before touching the register.
	// The first edge lets the checker's count include the last transfer.
	task automatic drain();
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_side(input logic [9:0] v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		cur_side = (v < 2) ? 2 : v;
	endtask

	// One transfer on the input channel, with optional idle cycles first.
	task automatic send(input logic kind, input logic [19:0] k, input logic [9:0] c,
		input logic [9:0] r);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {r, c, k};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	// Mostly legal queries, some off-grid and some raw noise.
	task automatic send_random();
		int n, nodes, sel;
		n = cur_side;
		nodes = (n + 1) * (n + 1);
		sel = $urandom_range(99);
		if (sel < 45)
			send(1'b0, 20'($urandom_range(nodes - 1)), 10'($urandom), 10'($urandom));
		else if (sel < 80)
			send(1'b1, 20'($urandom), 10'($urandom_range(n)), 10'($urandom_range(n)));
		else if (sel < 88)
			send(1'b0, 20'($urandom_range(nodes + 3, nodes)), 10'($urandom),
				10'($urandom));
		else
			send(1'($urandom), 20'($urandom), 10'($urandom), 10'($urandom));
	endtask

	initial begin
		int sides[7] = '{16, 2, 1023, 0, 1, 3, 37};
		int n;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: corners, each side, interior, off-grid, reset width.
		n = 16;
		send(1'b0, 20'd0, '0, '0);
		send(1'b0, 20'(n), '0, '0);
		send(1'b0, 20'(2 * n), '0, '0);
		send(1'b0, 20'(3 * n), '0, '0);
		send(1'b0, 20'(4 * n - 1), '0, '0);
		send(1'b0, 20'(4 * n), '0, '0);
		send(1'b0, 20'((n + 1) * (n + 1) - 1), '0, '0);
		send(1'b0, 20'((n + 1) * (n + 1)), '0, '0);
		send(1'b0, 20'hFFFFF, 10'h3FF, 10'h3FF);
		send(1'b1, '0, 10'd0, 10'd0);
		send(1'b1, '0, 10'(n), 10'(n));
		send(1'b1, '0, 10'd0, 10'(n));
		send(1'b1, '0, 10'(n), 10'd0);
		send(1'b1, '0, 10'd5, 10'd7);
		send(1'b1, 20'hFFFFF, 10'(n + 1), 10'd0);
		send(1'b1, '0, 10'd0, 10'(n + 1));
		send(1'b1, '0, 10'h3FF, 10'h3FF);
		s_tvalid <= 1'b0;

		// Random phases across register settings and idle mixes.
		for (int p = 0; p < 7; p++) begin
			drain();
			write_side(10'(sides[p]));
			case (p % 4)
				0: begin send_idle = 0;  recv_stall = 0;  end
				1: begin send_idle = 83; recv_stall = 0;  end
				2: begin send_idle = 0;  recv_stall = 83; end
				default: begin send_idle = 11; recv_stall = 11; end
			endcase
			send(1'b0, 20'((cur_side + 1) * (cur_side + 1) - 1), '0, '0);
			send(1'b1, 20'hFFFFF, 10'(cur_side), 10'(cur_side));
			for (int i = 0; i < 175; i++)
				send_random();
			s_tvalid <= 1'b0;
		end

		drain();
		if (errors == 0)
			$display("boundary_first_grid_index_mapper test passed");
		else
			$display("boundary_first_grid_index_mapper test failed");
		$finish;
	end
endmodule
